FILE: design/cgr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgr_pkg
// Shared widths, codes and types of the greedy register coloring block.
// ----------------------------------------------------------------------------
package cgr_pkg;

    localparam int NODE_W     = 8;
    localparam int COLOR_W    = 5;
    localparam int NCOL_W     = 6;
    localparam int MASK_W     = 32;
    localparam int NODES_DEF  = 256;
    localparam int MAX_COLORS = 32;

    localparam logic [NCOL_W-1:0] NCOL_RESET = 6'd16;

    localparam logic KIND_PRECOLOR = 1'b0;
    localparam logic KIND_NEIGHBOR = 1'b1;

    localparam logic [1:0] ST_ASSIGNED = 2'd0;
    localparam logic [1:0] ST_ALREADY  = 2'd1;
    localparam logic [1:0] ST_NO_FREE  = 2'd2;

    typedef struct packed {
        logic               en;
        logic [NODE_W-1:0]  node;
        logic [COLOR_W-1:0] color;
    } tbl_wr_t;

    typedef struct packed {
        logic               nb_valid;
        logic [COLOR_W-1:0] nb_color;
        logic               own_valid;
        logic [COLOR_W-1:0] own_color;
    } tbl_look_t;

endpackage
`default_nettype wire

FILE: design/cgr_ram.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgr_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module cgr_ram #(
    parameter int WIDTH = 5,
    parameter int DEPTH = 256
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
    input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic      [WIDTH-1:0]         rdata_a,
    output logic      [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    // read returns the old contents on a same-cycle write
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule
`default_nettype wire

FILE: design/cgr_table.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgr_table
// Node color table: valid bits in flops, colors in RAM, one-write bypass.
// ----------------------------------------------------------------------------
module cgr_table
    import cgr_pkg::*;
#(
    parameter int DEPTH = NODES_DEF
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic [NODE_W-1:0] rd_nb,
    input  wire logic [NODE_W-1:0] rd_own,
    input  wire tbl_wr_t           wr,
    output tbl_look_t              look
);

    localparam int IDX_W = $clog2(DEPTH);

    logic [NODE_W-1:0]  nb_reg;
    logic [NODE_W-1:0]  own_reg;
    logic               byp_en_reg;
    logic [NODE_W-1:0]  byp_node_reg;
    logic [COLOR_W-1:0] byp_color_reg;
    logic [DEPTH-1:0]   valid_reg;
    logic [DEPTH-1:0]   valid_next;
    logic               wr_in;
    logic               nb_in;
    logic               own_in;
    logic [COLOR_W-1:0] ram_nb;
    logic [COLOR_W-1:0] ram_own;

    assign wr_in  = wr.en && (32'(wr.node) < DEPTH);
    assign nb_in  = 32'(nb_reg) < DEPTH;
    assign own_in = 32'(own_reg) < DEPTH;

    cgr_ram #(
        .WIDTH (COLOR_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .aclk    (aclk),
        .we      (wr_in),
        .waddr   (IDX_W'(wr.node)),
        .wdata   (wr.color),
        .raddr_a (IDX_W'(rd_nb)),
        .raddr_b (IDX_W'(rd_own)),
        .rdata_a (ram_nb),
        .rdata_b (ram_own)
    );

    always_comb begin
        valid_next = valid_reg;
        if (wr_in) begin
            valid_next[IDX_W'(wr.node)] = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg  <= '0;
            byp_en_reg <= 1'b0;
        end else begin
            valid_reg  <= valid_next;
            byp_en_reg <= wr_in;
        end
        nb_reg        <= rd_nb;
        own_reg       <= rd_own;
        byp_node_reg  <= wr.node;
        byp_color_reg <= wr.color;
    end

    // a write on the same edge as the read is not yet in the ram data
    always_comb begin
        look.nb_valid  = nb_in && valid_reg[IDX_W'(nb_reg)];
        look.own_valid = own_in && valid_reg[IDX_W'(own_reg)];
        look.nb_color  = (byp_en_reg && byp_node_reg == nb_reg) ? byp_color_reg : ram_nb;
        look.own_color = (byp_en_reg && byp_node_reg == own_reg) ? byp_color_reg : ram_own;
    end

endmodule
`default_nettype wire

FILE: design/cgr_pick.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgr_pick
// First-fit pick: lowest color below the limit that is clear in the mask.
// ----------------------------------------------------------------------------
module cgr_pick
    import cgr_pkg::*;
(
    input  wire logic [MASK_W-1:0]  mask,
    input  wire logic [NCOL_W-1:0]  num_colors,
    output logic                    found,
    output logic      [COLOR_W-1:0] color
);

    logic [NCOL_W:0]     limit;
    logic [MASK_W-1:0]   allowed;
    logic [MASK_W-1:0]   free;
    logic [MASK_W-1:0]   lowest;

    always_comb begin
        limit = {1'b0, num_colors};
        if (32'(limit) > MAX_COLORS) begin
            limit = (NCOL_W+1)'(MAX_COLORS);
        end
        if (32'(limit) > MASK_W) begin
            limit = (NCOL_W+1)'(MASK_W);
        end
        for (int c = 0; c < MASK_W; c++) begin
            allowed[c] = (NCOL_W+1)'(c) < limit;
        end
        free   = ~mask & allowed;
        lowest = free & (~free + MASK_W'(1));
        found  = |free;
        color  = '0;
        for (int c = 0; c < MASK_W; c++) begin
            if (lowest[c]) begin
                color = color | COLOR_W'(c);
            end
        end
    end

endmodule
`default_nettype wire

FILE: design/greedy_register_coloring.sv
`default_nettype none
// ----------------------------------------------------------------------------
// greedy_register_coloring
// First-fit graph coloring of interference lists for register allocation.
// ----------------------------------------------------------------------------
// One transaction is accepted every cycle, except while a result item waits
// on m_ready in the lookup stage. An item's color table read (a two-port RAM
// with registered read, neighbor and own node) is issued as the item is
// accepted. The lookup stage then merges the neighbor's color into the used
// mask, picks the lowest free color on a last item and writes the table as
// the item leaves; the result enters the output register at the same time.
// A result waiting on m_ready holds only the next result item; precolor and
// non-last items keep flowing. The table's valid bits are flops cleared by
// reset, so no clearing pass follows reset. num_colors must be written through
// cfg_we/cfg_wdata only while the block idles; the block does not enforce it.
module greedy_register_coloring
    import cgr_pkg::*;
#(
    parameter int NODES = NODES_DEF
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               cfg_we,
    input  wire logic [NCOL_W-1:0]  cfg_wdata,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic               s_kind,
    input  wire logic [NODE_W-1:0]  s_node,
    input  wire logic [NODE_W-1:0]  s_neighbor,
    input  wire logic               s_neighbor_valid,
    input  wire logic [COLOR_W-1:0] s_color_in,
    input  wire logic               s_last,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic      [NODE_W-1:0]  m_node_out,
    output logic      [COLOR_W-1:0] m_color_out,
    output logic      [1:0]         m_status
);

    // node fields reach only the first 2**NODE_W entries
    localparam int TBL_DEPTH = (NODES < 2**NODE_W) ? NODES : 2**NODE_W;

    logic               s1_valid_reg;
    logic               s1_kind_reg;
    logic [NODE_W-1:0]  s1_node_reg;
    logic [NODE_W-1:0]  s1_neighbor_reg;
    logic               s1_nvalid_reg;
    logic [COLOR_W-1:0] s1_color_reg;
    logic               s1_last_reg;
    logic [MASK_W-1:0]  used_mask_reg;
    logic [MASK_W-1:0]  used_mask_next;
    logic [NCOL_W-1:0]  ncol_reg;
    logic               m_valid_reg;
    logic [NODE_W-1:0]  m_node_reg;
    logic [COLOR_W-1:0] m_color_reg;
    logic [1:0]         m_status_reg;

    logic               s_accept;
    logic               s1_res;
    logic               s1_go;
    logic [NODE_W-1:0]  rd_nb;
    logic [NODE_W-1:0]  rd_own;
    tbl_wr_t            wr;
    tbl_look_t          look;
    logic [MASK_W-1:0]  nb_bit;
    logic [MASK_W-1:0]  mask_all;
    logic               pick_found;
    logic [COLOR_W-1:0] pick_color;
    logic [COLOR_W-1:0] res_color;
    logic [1:0]         res_status;

    assign s1_res   = (s1_kind_reg == KIND_NEIGHBOR) && s1_last_reg;
    assign s1_go    = s1_valid_reg && (!s1_res || !m_valid_reg || m_ready);
    assign s_ready  = !s1_valid_reg || s1_go;
    assign s_accept = s_valid && s_ready;

    // reread the held item's entries while it waits
    assign rd_nb  = s_accept ? s_neighbor : s1_neighbor_reg;
    assign rd_own = s_accept ? s_node : s1_node_reg;

    cgr_table #(
        .DEPTH (TBL_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .aresetn (aresetn),
        .rd_nb   (rd_nb),
        .rd_own  (rd_own),
        .wr      (wr),
        .look    (look)
    );

    always_comb begin
        nb_bit = '0;
        if (s1_kind_reg == KIND_NEIGHBOR && s1_nvalid_reg && look.nb_valid) begin
            nb_bit = MASK_W'(1) << look.nb_color;
        end
        mask_all = used_mask_reg | nb_bit;
    end

    cgr_pick u_pick (
        .mask       (mask_all),
        .num_colors (ncol_reg),
        .found      (pick_found),
        .color      (pick_color)
    );

    always_comb begin
        if (look.own_valid) begin
            res_color  = look.own_color;
            res_status = ST_ALREADY;
        end else if (pick_found) begin
            res_color  = pick_color;
            res_status = ST_ASSIGNED;
        end else begin
            res_color  = '0;
            res_status = ST_NO_FREE;
        end

        wr.node  = s1_node_reg;
        wr.color = (s1_kind_reg == KIND_PRECOLOR) ? s1_color_reg : pick_color;
        wr.en    = s1_go && ((s1_kind_reg == KIND_PRECOLOR)
                             || (s1_res && !look.own_valid && pick_found));

        used_mask_next = used_mask_reg;
        if (s1_go && s1_kind_reg == KIND_NEIGHBOR) begin
            used_mask_next = s1_last_reg ? '0 : mask_all;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            used_mask_reg <= '0;
            ncol_reg      <= NCOL_RESET;
            m_valid_reg   <= 1'b0;
        end else begin
            if (s_accept) begin
                s1_valid_reg <= 1'b1;
            end else if (s1_go) begin
                s1_valid_reg <= 1'b0;
            end
            used_mask_reg <= used_mask_next;
            if (cfg_we) begin
                ncol_reg <= cfg_wdata;
            end
            if (s1_go && s1_res) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_accept) begin
            s1_kind_reg     <= s_kind;
            s1_node_reg     <= s_node;
            s1_neighbor_reg <= s_neighbor;
            s1_nvalid_reg   <= s_neighbor_valid;
            s1_color_reg    <= s_color_in;
            s1_last_reg     <= s_last;
        end
        if (s1_go && s1_res) begin
            m_node_reg   <= s1_node_reg;
            m_color_reg  <= res_color;
            m_status_reg <= res_status;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_node_out  = m_node_reg;
    assign m_color_out = m_color_reg;
    assign m_status    = m_status_reg;

endmodule
`default_nettype wire

FILE: design/cgr_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cgr_checker
// Port-level checks of the greedy register coloring block, bound to the top.
// ----------------------------------------------------------------------------
module cgr_checker
    import cgr_pkg::*;
(
    input wire logic               aclk,
    input wire logic               aresetn,
    input wire logic               cfg_we,
    input wire logic [NCOL_W-1:0]  cfg_wdata,
    input wire logic               s_valid,
    input wire logic               s_ready,
    input wire logic               s_kind,
    input wire logic               s_last,
    input wire logic               m_valid,
    input wire logic               m_ready,
    input wire logic [NODE_W-1:0]  m_node_out,
    input wire logic [COLOR_W-1:0] m_color_out,
    input wire logic [1:0]         m_status
);

    logic [NCOL_W-1:0] ncol_reg;

    // shadow of the color count register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ncol_reg <= NCOL_RESET;
        end else if (cfg_we) begin
            ncol_reg <= cfg_wdata;
        end
    end

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_node_out)
                                && $stable(m_color_out) && $stable(m_status))
        else $error("result changed while stalled");

    a_after_reset: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_valid)
        else $error("result valid right after reset");

    a_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s_valid && s_ready && s_kind == KIND_NEIGHBOR && s_last, 2))
        else $error("result without a last neighbor transaction");

    a_in_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == ST_ASSIGNED |-> {1'b0, m_color_out} < ncol_reg)
        else $error("assigned color not below num_colors");

endmodule

bind greedy_register_coloring cgr_checker u_cgr_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .s_valid     (s_valid),
    .s_ready     (s_ready),
    .s_kind      (s_kind),
    .s_last      (s_last),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_node_out  (m_node_out),
    .m_color_out (m_color_out),
    .m_status    (m_status)
);
`default_nettype wire
